/* src/fcr_pkg.sv */
// ---------------------------------------------------------------------------
// fcr_pkg: shared types and constants of the fire cell relaxation block
// Grid size, bank addressing, control codes and the structs between modules.
// ---------------------------------------------------------------------------
package fcr_pkg;

  localparam int WIDTH = 32;
  localparam int HEIGHT = 128;

  localparam int COL_W = $clog2(WIDTH);
  localparam int ROW_W = $clog2(HEIGHT);
  // Rows are interleaved over two banks by their lowest bit.
  localparam int BANK_AW = ROW_W - 1 + COL_W;
  localparam int SUM_W = 11;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_RELAX_LAST = ROW_W'(HEIGHT - 3);
  localparam logic [ROW_W-1:0] ROW_BOTTOM = ROW_W'(HEIGHT - 1);

  localparam logic [7:0] SEED_VALUE_RST = 8'd200;
  localparam logic [4:0] SEED_FIRST_RST = 5'd5;
  localparam logic [4:0] SEED_LAST_RST = 5'd23;

  localparam logic [1:0] REG_SEED_VALUE = 2'd0;
  localparam logic [1:0] REG_SEED_FIRST = 2'd1;
  localparam logic [1:0] REG_SEED_LAST = 2'd2;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED,
    ST_RELAX,
    ST_DRAIN,
    ST_READ,
    ST_READ_WAIT
  } state_t;

  typedef struct packed {
    logic [7:0] seed_value;
    logic [4:0] seed_first;
    logic [4:0] seed_last;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic               both;
    logic               bank;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         data;
  } wr_req_t;

  typedef struct packed {
    logic [1:0][BANK_AW-1:0] addr_a;
    logic [1:0][BANK_AW-1:0] addr_b;
  } rd_req_t;

  // Describes the column whose data leaves the banks in this cycle.
  typedef struct packed {
    logic             valid;
    logic             bank;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

endpackage

/* src/fcr_ram.sv */
// ---------------------------------------------------------------------------
// fcr_ram: one write port, two read ports, registered read data
// Generic synchronous memory used for one bank of the heat grid.
// ---------------------------------------------------------------------------
module fcr_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/fcr_window.sv */
// ---------------------------------------------------------------------------
// fcr_window: 3x3 stencil window and relaxation datapath
// Shifts in one column of three rows per cycle while tag.valid; produces the write-back.
// ---------------------------------------------------------------------------
module fcr_window
  import fcr_pkg::*;
(
  input  logic            clk,
  input  tag_t            tag,
  input  logic [1:0][7:0] q_a,
  input  logic [1:0][7:0] q_b,
  output wr_req_t         wr
);

  logic [7:0]       d0;
  logic [7:0]       d1;
  logic [7:0]       d2;
  logic [7:0]       w0l;
  logic [7:0]       w0m;
  logic [7:0]       w1l;
  logic [7:0]       w1m;
  logic [7:0]       w2l;
  logic [7:0]       w2m;
  logic [SUM_W-1:0] sum;
  logic             compute;
  logic [7:0]       relaxed;

  // The own row and the row two below share a bank; the middle row is in the other.
  assign d0 = q_a[tag.bank];
  assign d2 = q_b[tag.bank];
  assign d1 = q_a[!tag.bank];

  // A cell is finished when its right neighbor column arrives.
  assign compute = tag.valid && (tag.col >= COL_W'(2)) && (tag.col <= COL_W'(WIDTH - 2));

  assign sum = SUM_W'(w0l) + SUM_W'(w0m) + SUM_W'(d0)
             + SUM_W'(w1l) + SUM_W'(d1)
             + SUM_W'(w2l) + SUM_W'(w2m) + SUM_W'(d2);
  assign relaxed = sum[SUM_W-1:3];

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      // The updated cell becomes the left neighbor of the next one.
      w0l <= compute ? relaxed : w0m;
      w0m <= d0;
      w1l <= w1m;
      w1m <= d1;
      w2l <= w2m;
      w2m <= d2;
    end
  end

  always_comb begin
    wr.en   = compute;
    wr.both = 1'b0;
    wr.bank = tag.row[0];
    wr.addr = {tag.row[ROW_W-1:1], tag.col - COL_W'(1)};
    wr.data = relaxed;
  end

endmodule

/* src/fcr_ctrl.sv */
// ---------------------------------------------------------------------------
// fcr_ctrl: sequencer of the fire cell relaxation block
// Runs the clearing pass, bottom row seeding, the raster scan and reads.
// ---------------------------------------------------------------------------
module fcr_ctrl
  import fcr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            operation,
  input  logic [31:0]     random_bits,
  input  logic [4:0]      read_column,
  input  logic [6:0]      read_row,
  input  cfg_t            cfg,
  input  logic [1:0][7:0] q_a,
  output logic            busy,
  output wr_req_t         wr,
  output rd_req_t         rd,
  output tag_t            tag,
  output logic            done,
  output logic            result_kind,
  output logic [7:0]      cell_value
);

  state_t             state;
  state_t             state_next;
  logic [BANK_AW-1:0] clr_addr;
  logic [COL_W-1:0]   seed_col;
  logic [31:0]        seed_bits;
  logic [ROW_W-1:0]   row_cnt;
  logic [COL_W-1:0]   col_cnt;
  logic [BANK_AW-1:0] rd_addr;
  logic               rd_bank;
  logic               rd_oob;
  logic [ROW_W-1:0]   req_row;
  logic [COL_W-1:0]   req_col;
  logic [ROW_W-2:0]   yh;
  logic [ROW_W-2:0]   yh1;
  logic               seed_hit;
  logic [BANK_AW-1:0] own_addr;
  logic [BANK_AW-1:0] mid_addr;
  logic [BANK_AW-1:0] low_addr;

  assign req_row = ROW_W'(read_row);
  assign req_col = COL_W'(read_column);
  assign yh = row_cnt[ROW_W-1:1];
  assign yh1 = yh + (ROW_W - 1)'(1);
  assign seed_hit = (32'(seed_col) >= 32'(cfg.seed_first))
                 && (32'(seed_col) <= 32'(cfg.seed_last));
  assign own_addr = {yh, col_cnt};
  assign low_addr = {yh1, col_cnt};
  assign mid_addr = {row_cnt[0] ? yh1 : yh, col_cnt};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (operation == OP_READ) ? ST_READ : ST_SEED;
        end
      end
      ST_SEED: begin
        if (seed_col == COL_LAST) begin
          state_next = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (row_cnt == ROW_RELAX_LAST && col_cnt == COL_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:     state_next = ST_IDLE;
      ST_READ:      state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != ST_IDLE);
    wr.en   = 1'b0;
    wr.both = 1'b0;
    wr.bank = ROW_BOTTOM[0];
    wr.addr = {ROW_BOTTOM[ROW_W-1:1], seed_col};
    wr.data = seed_bits[0] ? cfg.seed_value : 8'd0;
    // Scan addresses: own row and the row two below from one bank, middle row from the other.
    rd.addr_a[0] = row_cnt[0] ? mid_addr : own_addr;
    rd.addr_a[1] = row_cnt[0] ? own_addr : mid_addr;
    rd.addr_b[0] = row_cnt[0] ? mid_addr : low_addr;
    rd.addr_b[1] = row_cnt[0] ? low_addr : mid_addr;
    unique case (state)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.both = 1'b1;
        wr.addr = clr_addr;
        wr.data = 8'd0;
      end
      ST_SEED: begin
        wr.en = seed_hit;
      end
      ST_READ: begin
        rd.addr_a[rd_bank] = rd_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag.bank <= row_cnt[0];
    tag.row  <= row_cnt;
    tag.col  <= col_cnt;
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      tag.valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      tag.valid <= (state == ST_RELAX);
      done      <= (state == ST_DRAIN) || (state == ST_READ_WAIT);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BANK_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        seed_bits <= random_bits;
        seed_col  <= '0;
        row_cnt   <= '0;
        col_cnt   <= '0;
        rd_addr   <= {req_row[ROW_W-1:1], req_col};
        rd_bank   <= req_row[0];
        rd_oob    <= !((32'(read_column) < WIDTH) && (32'(read_row) < HEIGHT));
      end
      ST_SEED: begin
        seed_col  <= seed_col + COL_W'(1);
        seed_bits <= seed_bits >> 1;
      end
      ST_RELAX: begin
        if (col_cnt == COL_LAST) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + COL_W'(1);
        end
      end
      ST_DRAIN: begin
        result_kind <= KIND_FRAME;
        cell_value  <= 8'd0;
      end
      ST_READ_WAIT: begin
        result_kind <= KIND_READ;
        cell_value  <= rd_oob ? 8'd0 : q_a[rd_bank];
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/fire_cell_relaxation.sv */
// ---------------------------------------------------------------------------
// fire_cell_relaxation: heat buffer of a classic fire effect
// Seeds the bottom row, relaxes the grid in raster order, and reads cells.
// ---------------------------------------------------------------------------
//   Channel   Handshake                   Payload
//   item in   start, accepted when !busy  operation, random_bits, read_column, read_row
//   result    done, one cycle per item    result_kind, cell_value
//   config    APB write/read, pready = 1  seed_value, seed_first, seed_last
//
// A frame item seeds the bottom row, relaxes the grid row by row and then drains;
// the grid lives in two row-interleaved banks, so all three rows of one column are
// read in the same cycle.
// A read item goes through ST_READ and ST_READ_WAIT, then its result is registered.
// After reset a clearing pass over every bank address keeps busy high.
// Results cannot be held off; done marks each one for a single cycle.
module fire_cell_relaxation
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [31:0] random_bits,
  input  logic [4:0]  read_column,
  input  logic [6:0]  read_row,
  output logic        done,
  output logic        result_kind,
  output logic [7:0]  cell_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t               cfg;
  wr_req_t            ctrl_wr;
  wr_req_t            win_wr;
  rd_req_t            rd;
  tag_t               tag;
  logic [1:0][7:0]    q_a;
  logic [1:0][7:0]    q_b;
  logic [1:0]         bank_we;
  logic [1:0][BANK_AW-1:0] bank_waddr;
  logic [1:0][7:0]    bank_wdata;
  logic               cfg_write;
  logic [1:0]         reg_index;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed_value <= SEED_VALUE_RST;
      cfg.seed_first <= SEED_FIRST_RST;
      cfg.seed_last  <= SEED_LAST_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_SEED_VALUE: cfg.seed_value <= pwdata[7:0];
        REG_SEED_FIRST: cfg.seed_first <= pwdata[4:0];
        REG_SEED_LAST:  cfg.seed_last  <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SEED_VALUE: prdata = {24'd0, cfg.seed_value};
      REG_SEED_FIRST: prdata = {27'd0, cfg.seed_first};
      REG_SEED_LAST:  prdata = {27'd0, cfg.seed_last};
      default:        prdata = 32'd0;
    endcase
  end

  fcr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .random_bits (random_bits),
    .read_column (read_column),
    .read_row    (read_row),
    .cfg         (cfg),
    .q_a         (q_a),
    .busy        (busy),
    .wr          (ctrl_wr),
    .rd          (rd),
    .tag         (tag),
    .done        (done),
    .result_kind (result_kind),
    .cell_value  (cell_value)
  );

  fcr_window u_window (
    .clk (clk),
    .tag (tag),
    .q_a (q_a),
    .q_b (q_b),
    .wr  (win_wr)
  );

  // The sequencer and the relaxation datapath never write in the same cycle.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (ctrl_wr.en) begin
        bank_we[k]    = ctrl_wr.both || (ctrl_wr.bank == 1'(k));
        bank_waddr[k] = ctrl_wr.addr;
        bank_wdata[k] = ctrl_wr.data;
      end else begin
        bank_we[k]    = win_wr.en && (win_wr.bank == 1'(k));
        bank_waddr[k] = win_wr.addr;
        bank_wdata[k] = win_wr.data;
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_bank
    fcr_ram #(
      .ADDR_W (BANK_AW),
      .DATA_W (8)
    ) u_ram (
      .clk     (clk),
      .we      (bank_we[g]),
      .waddr   (bank_waddr[g]),
      .wdata   (bank_wdata[g]),
      .raddr_a (rd.addr_a[g]),
      .raddr_b (rd.addr_b[g]),
      .rdata_a (q_a[g]),
      .rdata_b (q_b[g])
    );
  end

endmodule

/* src/fcr_checker.sv */
// ---------------------------------------------------------------------------
// fcr_checker: port-level checks of the fire cell relaxation block
// Watches the item and result ports over time; attached by a bind.
// ---------------------------------------------------------------------------
module fcr_checker
  import fcr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       operation,
  input logic       done,
  input logic       result_kind,
  input logic [7:0] cell_value
);

  // Reset always starts the clearing pass.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in work");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_READ |-> ##3 (done && result_kind == KIND_READ))
    else $error("read item result missing three cycles after acceptance");

  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    done && result_kind == KIND_FRAME |-> cell_value == 8'd0)
    else $error("frame result carries a nonzero cell value");

endmodule

bind fire_cell_relaxation fcr_checker u_fcr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .operation   (operation),
  .done        (done),
  .result_kind (result_kind),
  .cell_value  (cell_value)
);

/* dv/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: testbench of the fire cell relaxation block
// Feeds frame and cell read items through the start/busy handshake, keeps its
// own copy of the heat grid and the seed registers, and checks every result
// strobe against the predicted kind and heat value in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fcr_pkg::*;

  typedef struct {
    logic        kind;
    logic [7:0]  value;
  } cell_result_t;

  // One row of the directed part. Rows with typed_in set carry the result that
  // is plain at a glance; the others take it from the grid predictor.
  typedef struct {
    logic        op;
    logic [31:0] bits;
    logic [4:0]  col;
    logic [6:0]  row;
    bit          typed_in;
    logic [7:0]  value;
  } directed_row_t;

  localparam int NUM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 17;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [31:0] random_bits;
  logic [4:0]  read_column;
  logic [6:0]  read_row;
  logic        done;
  logic        result_kind;
  logic [7:0]  cell_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted heat grid and seed registers.
  logic [7:0] heat [HEIGHT][WIDTH];
  logic [7:0] seed_heat;
  logic [4:0] seed_lo;
  logic [4:0] seed_hi;

  cell_result_t results_due[$];
  int mismatches = 0;
  int frames_seen = 0;
  int reads_seen = 0;
  int settings_used = 1;

  fire_cell_relaxation i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .random_bits (random_bits),
    .read_column (read_column),
    .read_row    (read_row),
    .done        (done),
    .result_kind (result_kind),
    .cell_value  (cell_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Seeds the bottom row, then relaxes the grid in place in raster order.
  function automatic void fire_frame(input logic [31:0] bits);
    int s;
    for (int c = seed_lo; c <= seed_hi && c < WIDTH; c++) begin
      heat[HEIGHT-1][c] = bits[c] ? seed_heat : 8'd0;
    end
    for (int y = 0; y + 2 < HEIGHT; y++) begin
      for (int x = 1; x + 2 < WIDTH; x++) begin
        s = int'(heat[y][x-1]) + int'(heat[y][x]) + int'(heat[y][x+1])
          + int'(heat[y+1][x-1]) + int'(heat[y+1][x+1])
          + int'(heat[y+2][x-1]) + int'(heat[y+2][x]) + int'(heat[y+2][x+1]);
        heat[y][x] = 8'(s >> 3);
      end
    end
  endfunction

  function automatic logic [7:0] fire_cell(input logic [4:0] col, input logic [6:0] row);
    if (int'(col) >= WIDTH || int'(row) >= HEIGHT) begin
      return 8'd0;
    end
    return heat[row][col];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Presents one item, waits for it to be taken and records its result. With
  // no gap, start stays high so the next item follows directly.
  task automatic issue_item(input logic op, input logic [31:0] bits, input logic [4:0] col,
                            input logic [6:0] row, input bit typed_in,
                            input logic [7:0] typed_value);
    cell_result_t due;
    int gap;
    start       <= 1'b1;
    operation   <= op;
    random_bits <= bits;
    read_column <= col;
    read_row    <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_FRAME) begin
      fire_frame(bits);
      due.kind  = KIND_FRAME;
      due.value = 8'd0;
    end else begin
      due.kind  = KIND_READ;
      due.value = fire_cell(col, row);
    end
    if (typed_in) begin
      due.value = typed_value;
    end
    results_due.push_back(due);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_SEED_VALUE: seed_heat = value[7:0];
      REG_SEED_FIRST: seed_lo = value[4:0];
      REG_SEED_LAST:  seed_hi = value[4:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Lets the block drain and go idle before the seed registers change.
  task automatic set_seeding(input logic [31:0] heat_val, input logic [31:0] lo,
                             input logic [31:0] hi);
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0 || busy) @(posedge clk);
    write_reg(REG_SEED_VALUE, heat_val);
    write_reg(REG_SEED_FIRST, lo);
    write_reg(REG_SEED_LAST, hi);
    settings_used++;
  endtask

  task automatic random_item();
    logic [31:0] bits;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        bits = '1;
      end else if (r < 40) begin
        bits = '0;
      end else begin
        bits = $urandom;
      end
      issue_item(OP_FRAME, bits, 5'($urandom), 7'($urandom), 1'b0, 8'd0);
    end else if (r < 75) begin
      // Heat lives near the bottom, so most reads look there.
      issue_item(OP_READ, $urandom, 5'($urandom_range(0, WIDTH - 1)),
                 7'($urandom_range(HEIGHT - 16, HEIGHT - 1)), 1'b0, 8'd0);
    end else begin
      issue_item(OP_READ, $urandom, 5'($urandom_range(0, WIDTH - 1)),
                 7'($urandom_range(0, HEIGHT - 1)), 1'b0, 8'd0);
    end
  endtask

  always @(posedge clk) begin : result_check
    cell_result_t due;
    if (!rst && done === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result with none pending: kind %0d value %0d",
                                  result_kind, cell_value));
      end else begin
        due = results_due.pop_front();
        if (result_kind !== due.kind) begin
          report_mismatch($sformatf("result_kind %0d, predicted %0d", result_kind, due.kind));
        end
        if (cell_value !== due.value) begin
          report_mismatch($sformatf("cell_value %0d, predicted %0d", cell_value, due.value));
        end
        if (due.kind == KIND_FRAME) begin
          frames_seen++;
        end else begin
          reads_seen++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    directed_row_t directed[$];
    logic [31:0] phase_cfg [5][3];

    rst         <= 1'b1;
    start       <= 1'b0;
    operation   <= OP_FRAME;
    random_bits <= '0;
    read_column <= '0;
    read_row    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    for (int y = 0; y < HEIGHT; y++) begin
      for (int x = 0; x < WIDTH; x++) begin
        heat[y][x] = 8'd0;
      end
    end
    seed_heat = SEED_VALUE_RST;
    seed_lo   = SEED_FIRST_RST;
    seed_hi   = SEED_LAST_RST;

    // Column and row fields cannot address outside the grid at this size.
    directed = '{
      '{OP_READ,  32'h0,         5'd0,  7'd0,   1'b1, 8'd0},
      '{OP_READ,  32'hFFFF_FFFF, 5'd31, 7'd127, 1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd31, 7'd0,   1'b1, 8'd0},
      '{OP_FRAME, 32'h0,         5'd31, 7'd127, 1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd15, 7'd127, 1'b1, 8'd0},
      '{OP_FRAME, 32'hFFFF_FFFF, 5'd0,  7'd0,   1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd5,  7'd127, 1'b1, 8'd200},
      '{OP_READ,  32'h0,         5'd23, 7'd127, 1'b1, 8'd200},
      '{OP_READ,  32'h0,         5'd4,  7'd127, 1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd24, 7'd127, 1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd0,  7'd127, 1'b1, 8'd0},
      '{OP_FRAME, 32'h5555_5555, 5'd0,  7'd0,   1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd5,  7'd127, 1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd6,  7'd127, 1'b1, 8'd200},
      '{OP_READ,  32'h0,         5'd10, 7'd125, 1'b0, 8'd0},
      '{OP_READ,  32'h0,         5'd10, 7'd126, 1'b0, 8'd0},
      '{OP_READ,  32'h0,         5'd1,  7'd125, 1'b0, 8'd0},
      '{OP_READ,  32'h0,         5'd29, 7'd125, 1'b0, 8'd0},
      '{OP_READ,  32'h0,         5'd30, 7'd125, 1'b0, 8'd0},
      '{OP_FRAME, 32'hFFFF_FFFF, 5'd0,  7'd0,   1'b1, 8'd0},
      '{OP_FRAME, 32'h8000_0001, 5'd0,  7'd0,   1'b1, 8'd0},
      '{OP_READ,  32'h0,         5'd16, 7'd124, 1'b0, 8'd0},
      '{OP_READ,  32'h0,         5'd16, 7'd126, 1'b0, 8'd0},
      '{OP_READ,  32'h0,         5'd15, 7'd0,   1'b0, 8'd0}
    };

    // Full range at both heat extremes, a single edge column, an empty range
    // with first above last, and a narrow range; later phases are random.
    phase_cfg = '{
      '{32'd255, 32'd0,  32'd31},
      '{32'd0,   32'd0,  32'd31},
      '{32'd255, 32'd31, 32'd31},
      '{32'd255, 32'd31, 32'd0},
      '{32'd128, 32'd0,  32'd0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      issue_item(directed[i].op, directed[i].bits, directed[i].col, directed[i].row,
                 directed[i].typed_in, directed[i].value);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 5) begin
        set_seeding(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      end else begin
        set_seeding($urandom, $urandom, $urandom);
      end
      repeat (ITEMS_PER_PHASE) random_item();
    end

    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d frame results and %0d cell reads", frames_seen, reads_seen);
    $display("Seed register settings exercised: %0d", settings_used);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
